/* hdl/rrsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsm_pkg
// Shared types and constants of the round-robin schedule metrics unit.
// ----------------------------------------------------------------------------
package rrsm_pkg;

  localparam int BURST_W       = 16;
  localparam int QUANTUM_W     = 16;
  localparam int JOB_NUM_W     = 5;
  localparam int TIME_OUT_W    = 21;
  localparam int OUT_TDATA_W   = 72;
  localparam int OUT_PAD_W     = OUT_TDATA_W - JOB_NUM_W - 3 * TIME_OUT_W;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_POP,
    ST_FETCH,
    ST_SERVE,
    ST_OREAD,
    ST_OEMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // store one job
    logic fetch;  // take the job at the queue head
    logic serve;  // run one slice of the fetched job
    logic emit;   // move one record into the output register
    logic clear;  // return batch state to its reset values
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic batch_last;  // the slice being served finishes the final job
    logic rec_last;    // current record belongs to the final job
    logic out_free;    // output register can take a record this cycle
  } stat_t;

endpackage

/* hdl/rrsm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsm_ctrl
// Sequencer: load jobs, run slices off the ready queue, then read out records.
// ----------------------------------------------------------------------------
module rrsm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  rrsm_pkg::stat_t stat,
  output rrsm_pkg::cmd_t  cmd
);

  rrsm_pkg::state_t state;
  rrsm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrsm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      rrsm_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = rrsm_pkg::ST_POP;
          end
        end
      end
      rrsm_pkg::ST_POP: begin
        // queue head read is in flight
        state_next = rrsm_pkg::ST_FETCH;
      end
      rrsm_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = rrsm_pkg::ST_SERVE;
      end
      rrsm_pkg::ST_SERVE: begin
        cmd.serve = 1'b1;
        if (stat.batch_last) begin
          state_next = rrsm_pkg::ST_OREAD;
        end else begin
          state_next = rrsm_pkg::ST_POP;
        end
      end
      rrsm_pkg::ST_OREAD: begin
        state_next = rrsm_pkg::ST_OEMIT;
      end
      rrsm_pkg::ST_OEMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.rec_last) begin
            cmd.clear  = 1'b1;
            state_next = rrsm_pkg::ST_LOAD;
          end else begin
            state_next = rrsm_pkg::ST_OREAD;
          end
        end
      end
      default: begin
        state_next = rrsm_pkg::ST_LOAD;
      end
    endcase
  end

  property p_serve_after_fetch;
    @(posedge clk) disable iff (rst) cmd.serve |-> $past(cmd.fetch);
  endproperty
  a_serve_after_fetch: assert property (p_serve_after_fetch)
    else $error("slice served without a fetched job");

  property p_clear_only_on_emit;
    @(posedge clk) disable iff (rst) cmd.clear |-> (cmd.emit && stat.rec_last);
  endproperty
  a_clear_only_on_emit: assert property (p_clear_only_on_emit)
    else $error("batch cleared before the final record");

  property p_no_load_while_busy;
    @(posedge clk) disable iff (rst)
      (cmd.fetch || cmd.serve || cmd.emit) |-> !in_ready;
  endproperty
  a_no_load_while_busy: assert property (p_no_load_while_busy)
    else $error("input taken while a batch is being worked");

endmodule

/* hdl/rrsm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsm_datapath
// Job stores, circular ready queue, time counter and output register.
// ----------------------------------------------------------------------------
module rrsm_datapath #(
  parameter int MAX_JOBS  = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rrsm_pkg::QUANTUM_W-1:0]      cfg_quantum,
  input  logic [rrsm_pkg::BURST_W-1:0]        burst_time,
  input  rrsm_pkg::cmd_t                      cmd,
  output rrsm_pkg::stat_t                     stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [rrsm_pkg::JOB_NUM_W-1:0]      job_number,
  output logic [rrsm_pkg::TIME_OUT_W-1:0]     completion_time,
  output logic [rrsm_pkg::TIME_OUT_W-1:0]     waiting_time,
  output logic [rrsm_pkg::TIME_OUT_W-1:0]     response_time,
  output logic                                last_record
);

  localparam int JW = $clog2(MAX_JOBS);
  localparam int CW = TIME_BITS + JW;
  localparam int WW = (CW > rrsm_pkg::QUANTUM_W) ? CW : rrsm_pkg::QUANTUM_W;
  localparam logic [JW-1:0] LAST_IDX = JW'(MAX_JOBS - 1);
  localparam logic [JW:0]   FULL_CNT = (JW + 1)'(MAX_JOBS);

  logic [TIME_BITS-1:0] burst_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] rem_mem   [MAX_JOBS];
  logic [CW-1:0]        comp_mem  [MAX_JOBS];
  logic [CW-1:0]        resp_mem  [MAX_JOBS];
  logic [JW-1:0]        queue_mem [MAX_JOBS];

  logic [rrsm_pkg::QUANTUM_W-1:0] quantum;
  logic [JW:0]          jobs_loaded;
  logic [JW:0]          jobs_done;
  logic [JW-1:0]        head;
  logic [JW-1:0]        tail;
  logic [CW-1:0]        clock_now;
  logic [MAX_JOBS-1:0]  started;
  logic [JW-1:0]        rec_idx;
  logic [JW-1:0]        job;

  logic [JW-1:0]        q_rdata;
  logic [TIME_BITS-1:0] rem_rdata;
  logic [TIME_BITS-1:0] burst_rdata;
  logic [CW-1:0]        comp_rdata;
  logic [CW-1:0]        resp_rdata;

  logic                 load_ok;
  logic [JW-1:0]        load_idx;
  logic [TIME_BITS-1:0] burst_eff;
  logic [WW-1:0]        slice_w;
  logic [WW-1:0]        rem_w;
  logic                 requeue;
  logic [WW-1:0]        serve_amt;
  logic [CW-1:0]        clock_next;
  logic [TIME_BITS-1:0] rem_next;
  logic                 rec_last;
  logic [CW-1:0]        wait_full;

  function automatic logic [JW-1:0] wrap_inc(input logic [JW-1:0] x);
    wrap_inc = (x == LAST_IDX) ? '0 : x + JW'(1);
  endfunction

  assign load_ok   = jobs_loaded < FULL_CNT;
  assign load_idx  = jobs_loaded[JW-1:0];
  assign burst_eff = TIME_BITS'(burst_time);

  // zero quantum behaves as one
  assign slice_w    = (quantum == '0) ? WW'(1) : WW'(quantum);
  assign rem_w      = WW'(rem_rdata);
  assign requeue    = rem_w > slice_w;
  assign serve_amt  = requeue ? slice_w : rem_w;
  assign clock_next = clock_now + CW'(serve_amt);
  assign rem_next   = requeue ? TIME_BITS'(rem_w - slice_w) : '0;

  assign rec_last  = ((JW + 1)'(rec_idx) + (JW + 1)'(1)) == jobs_loaded;
  assign wait_full = comp_rdata - CW'(burst_rdata);

  assign stat.batch_last = !requeue && ((jobs_done + (JW + 1)'(1)) == jobs_loaded);
  assign stat.rec_last   = rec_last;
  assign stat.out_free   = !out_valid || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= rrsm_pkg::QUANTUM_RESET;
    end else if (cfg_we) begin
      quantum <= cfg_quantum;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      burst_mem[load_idx] <= burst_eff;
    end
    burst_rdata <= burst_mem[rec_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      rem_mem[load_idx] <= burst_eff;
    end else if (cmd.serve) begin
      rem_mem[job] <= rem_next;
    end
    rem_rdata <= rem_mem[q_rdata];
  end

  always_ff @(posedge clk) begin
    if (cmd.serve && !requeue) begin
      comp_mem[job] <= clock_next;
    end
    comp_rdata <= comp_mem[rec_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.serve && !started[job]) begin
      resp_mem[job] <= clock_now;
    end
    resp_rdata <= resp_mem[rec_idx];
  end

  // queue starts out holding every job in load order
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      queue_mem[load_idx] <= load_idx;
    end else if (cmd.serve && requeue) begin
      queue_mem[tail] <= job;
    end
    q_rdata <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      job <= q_rdata;
    end
  end

  // batch control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      jobs_loaded <= '0;
      jobs_done   <= '0;
      head        <= '0;
      tail        <= '0;
      clock_now   <= '0;
      started     <= '0;
      rec_idx     <= '0;
    end else begin
      if (cmd.load && load_ok) begin
        jobs_loaded       <= jobs_loaded + (JW + 1)'(1);
        tail              <= wrap_inc(load_idx);
        started[load_idx] <= 1'b0;
      end
      if (cmd.fetch) begin
        head <= wrap_inc(head);
      end
      if (cmd.serve) begin
        clock_now    <= clock_next;
        started[job] <= 1'b1;
        if (requeue) begin
          tail <= wrap_inc(tail);
        end else begin
          jobs_done <= jobs_done + (JW + 1)'(1);
        end
      end
      if (cmd.emit) begin
        rec_idx <= rec_idx + JW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      job_number      <= rrsm_pkg::JOB_NUM_W'(rec_idx);
      completion_time <= rrsm_pkg::TIME_OUT_W'(comp_rdata);
      waiting_time    <= rrsm_pkg::TIME_OUT_W'(wait_full);
      response_time   <= rrsm_pkg::TIME_OUT_W'(resp_rdata);
      last_record     <= rec_last;
    end
  end

  property p_done_bounded;
    @(posedge clk) disable iff (rst) jobs_done <= jobs_loaded;
  endproperty
  a_done_bounded: assert property (p_done_bounded)
    else $error("more jobs finished than loaded");

  property p_loaded_bounded;
    @(posedge clk) disable iff (rst) jobs_loaded <= FULL_CNT;
  endproperty
  a_loaded_bounded: assert property (p_loaded_bounded)
    else $error("job count beyond store depth");

  property p_clear_resets;
    @(posedge clk) disable iff (rst)
      cmd.clear |=> (clock_now == '0 && jobs_loaded == '0 && started == '0);
  endproperty
  a_clear_resets: assert property (p_clear_resets)
    else $error("batch state not cleared");

  property p_emit_no_overwrite;
    @(posedge clk) disable iff (rst) cmd.emit |-> (!out_valid || out_ready);
  endproperty
  a_emit_no_overwrite: assert property (p_emit_no_overwrite)
    else $error("record overwritten before it was taken");

endmodule

/* hdl/round_robin_schedule_metrics_unit.sv */
`timescale 1ns / 1ps
// Round-robin schedule metrics: jobs stream in one burst time per transaction,
// one per cycle while jobs are being loaded, with tlast closing the batch; jobs
// beyond MAX_JOBS are dropped. On the closing transaction the unit serves the
// circular ready queue one slice at a time (queue read, remaining-time read,
// update), so a job gets max(1, ceil(burst / quantum)) slices. Then it returns
// one record per job in load order, each through a store read and the output
// register, held back by any output stall. New jobs are taken once the final
// record sits in the output register. The quantum may only be written while no
// batch is in progress; a quantum of zero acts as one.
// ----------------------------------------------------------------------------
// round_robin_schedule_metrics_unit
// Top level: stream ports, configuration port, sequencer and datapath.
// ----------------------------------------------------------------------------
module round_robin_schedule_metrics_unit #(
  parameter int MAX_JOBS  = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rrsm_pkg::QUANTUM_W-1:0]       cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [rrsm_pkg::BURST_W-1:0]         s_axis_tdata,  // [15:0] burst_time
  input  logic                                 s_axis_tlast,  // last_job
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [4:0] job_number, [25:5] completion_time, [46:26] waiting_time,
  // [67:47] response_time, [71:68] zero
  output logic [rrsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast   // last_record
);

  rrsm_pkg::cmd_t  cmd;
  rrsm_pkg::stat_t stat;

  logic [rrsm_pkg::JOB_NUM_W-1:0]  job_number;
  logic [rrsm_pkg::TIME_OUT_W-1:0] completion_time;
  logic [rrsm_pkg::TIME_OUT_W-1:0] waiting_time;
  logic [rrsm_pkg::TIME_OUT_W-1:0] response_time;

  assign cfg_ready = 1'b1;

  rrsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrsm_datapath #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_quantum     (cfg_data),
    .burst_time      (s_axis_tdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .job_number      (job_number),
    .completion_time (completion_time),
    .waiting_time    (waiting_time),
    .response_time   (response_time),
    .last_record     (m_axis_tlast)
  );

  assign m_axis_tdata = {{rrsm_pkg::OUT_PAD_W{1'b0}}, response_time, waiting_time,
                         completion_time, job_number};

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams batches of job burst times into the round-robin schedule metrics
// unit under several quantum settings. A software round-robin scheduler
// predicts the per-job completion, waiting and response records, and the
// record stream is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_JOBS         = 32;
  localparam int RANDOM_PER_PHASE = 28;
  localparam int SETTLE_CYCLES    = 8;
  localparam int QUIET_LIMIT      = 10000;
  localparam int SLICES_PER_JOB   = 16;

  typedef struct {
    logic [rrsm_pkg::BURST_W-1:0] burst;
    logic                         last;
  } job_item_t;

  typedef struct {
    logic [rrsm_pkg::JOB_NUM_W-1:0]  job;
    logic [rrsm_pkg::TIME_OUT_W-1:0] completion;
    logic [rrsm_pkg::TIME_OUT_W-1:0] waiting;
    logic [rrsm_pkg::TIME_OUT_W-1:0] response;
    logic                            last;
  } job_record_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rrsm_pkg::QUANTUM_W-1:0]   cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rrsm_pkg::BURST_W-1:0]     s_axis_tdata = '0;   // [15:0] burst_time
  logic                             s_axis_tlast = 1'b0; // last_job
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // [4:0] job_number, [25:5] completion_time, [46:26] waiting_time,
  // [67:47] response_time, [71:68] zero
  logic [rrsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;        // last_record

  // scheduler prediction state
  logic [rrsm_pkg::QUANTUM_W-1:0]   quantum_reg = rrsm_pkg::QUANTUM_RESET;
  logic [rrsm_pkg::BURST_W-1:0]     stored_bursts [MAX_JOBS];
  int                               stored_count = 0;

  job_item_t              job_feed [$];
  job_record_t            job_records [$];
  job_item_t              next_job;
  job_record_t            want_rec;
  int                     idle_pct = 19;
  int                     error_count = 0;
  int                     quiet_cycles = 0;

  round_robin_schedule_metrics_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // store one job; the closing job runs the round-robin schedule
  function automatic void schedule_job(input logic [rrsm_pkg::BURST_W-1:0] burst,
                                       input logic closing);
    longint      remaining [MAX_JOBS];
    longint      first_served [MAX_JOBS];
    longint      finished [MAX_JOBS];
    bit          served [MAX_JOBS];
    int          ready_order [$];
    longint      now;
    longint      slice;
    int          done_count;
    int          job;
    int          k;
    job_record_t rec;
    if (stored_count < MAX_JOBS) begin
      stored_bursts[stored_count] = burst;
      stored_count++;
    end
    if (!closing) return;
    slice = (quantum_reg == 0) ? 1 : longint'(quantum_reg);
    now = 0;
    done_count = 0;
    for (k = 0; k < stored_count; k++) begin
      remaining[k] = longint'(stored_bursts[k]);
      served[k] = 1'b0;
      ready_order.push_back(k);
    end
    while (done_count < stored_count) begin
      job = ready_order.pop_front();
      if (!served[job]) begin
        served[job] = 1'b1;
        first_served[job] = now;
      end
      if (remaining[job] > slice) begin
        now += slice;
        remaining[job] -= slice;
        ready_order.push_back(job);
      end else begin
        now += remaining[job];
        remaining[job] = 0;
        finished[job] = now;
        done_count++;
      end
    end
    for (k = 0; k < stored_count; k++) begin
      rec.job        = k[rrsm_pkg::JOB_NUM_W-1:0];
      rec.completion = finished[k][rrsm_pkg::TIME_OUT_W-1:0];
      rec.waiting    = rrsm_pkg::TIME_OUT_W'(finished[k] - longint'(stored_bursts[k]));
      rec.response   = first_served[k][rrsm_pkg::TIME_OUT_W-1:0];
      rec.last       = (k == stored_count - 1);
      job_records.push_back(rec);
    end
    stored_count = 0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // job driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        schedule_job(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (job_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_job = job_feed.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_job.burst;
          s_axis_tlast  <= next_job.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // record monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (job_records.size() == 0) begin
          report_mismatch("unexpected record, job_number",
                          longint'(m_axis_tdata[rrsm_pkg::JOB_NUM_W-1:0]), longint'(-1));
        end else begin
          want_rec = job_records.pop_front();
          if (m_axis_tdata[rrsm_pkg::JOB_NUM_W-1:0] !== want_rec.job)
            report_mismatch("job_number", longint'(m_axis_tdata[rrsm_pkg::JOB_NUM_W-1:0]),
                            longint'(want_rec.job));
          if (m_axis_tdata[rrsm_pkg::JOB_NUM_W +: rrsm_pkg::TIME_OUT_W] !== want_rec.completion)
            report_mismatch("completion_time",
                            longint'(m_axis_tdata[rrsm_pkg::JOB_NUM_W +: rrsm_pkg::TIME_OUT_W]),
                            longint'(want_rec.completion));
          if (m_axis_tdata[rrsm_pkg::JOB_NUM_W + rrsm_pkg::TIME_OUT_W +: rrsm_pkg::TIME_OUT_W]
              !== want_rec.waiting)
            report_mismatch("waiting_time",
                            longint'(m_axis_tdata[rrsm_pkg::JOB_NUM_W + rrsm_pkg::TIME_OUT_W +:
                                                  rrsm_pkg::TIME_OUT_W]),
                            longint'(want_rec.waiting));
          if (m_axis_tdata[rrsm_pkg::JOB_NUM_W + 2 * rrsm_pkg::TIME_OUT_W +: rrsm_pkg::TIME_OUT_W]
              !== want_rec.response)
            report_mismatch("response_time",
                            longint'(m_axis_tdata[rrsm_pkg::JOB_NUM_W + 2 * rrsm_pkg::TIME_OUT_W +:
                                                  rrsm_pkg::TIME_OUT_W]),
                            longint'(want_rec.response));
          if (m_axis_tdata[rrsm_pkg::OUT_TDATA_W-1 -: rrsm_pkg::OUT_PAD_W] !== '0)
            report_mismatch("pad bits",
                            longint'(m_axis_tdata[rrsm_pkg::OUT_TDATA_W-1 -: rrsm_pkg::OUT_PAD_W]),
                            longint'(0));
          if (m_axis_tlast !== want_rec.last)
            report_mismatch("last_record", longint'(m_axis_tlast), longint'(want_rec.last));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_job(input logic [rrsm_pkg::BURST_W-1:0] burst, input logic closing);
    job_item_t item;
    item.burst = burst;
    item.last  = closing;
    job_feed.push_back(item);
  endtask

  // bursts are capped at SLICES_PER_JOB quanta (and at 65535), so no job needs more than SLICES_PER_JOB slices
  task automatic add_random_batch(input int jobs);
    longint                       cap;
    int                           k;
    int                           pick;
    logic [rrsm_pkg::BURST_W-1:0] burst;
    cap = ((quantum_reg == 0) ? 1 : longint'(quantum_reg)) * SLICES_PER_JOB;
    if (cap > 65535) cap = 65535;
    for (k = 0; k < jobs; k++) begin
      pick = int'($urandom_range(7));
      if (pick == 0) burst = '0;
      else if (pick == 1) burst = cap[rrsm_pkg::BURST_W-1:0];
      else burst = rrsm_pkg::BURST_W'($urandom_range(cap[31:0], 0));
      add_job(burst, k == jobs - 1);
    end
  endtask

  // sender holds off until every record is back and the unit is quiet
  task automatic drain_all();
    @(negedge clk);
    while (job_feed.size() != 0 || s_axis_tvalid || job_records.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [rrsm_pkg::QUANTUM_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    quantum_reg = value;
  endtask

  initial begin
    logic [rrsm_pkg::QUANTUM_W-1:0] phase_quantum [5];
    int                             p;
    int                             queued;
    int                             jobs;
    phase_quantum[0] = rrsm_pkg::QUANTUM_RESET;
    phase_quantum[1] = '0;
    phase_quantum[2] = '1;
    phase_quantum[3] = 16'd1;
    phase_quantum[4] = rrsm_pkg::QUANTUM_W'($urandom_range(65535, 2));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (p = 0; p < 5; p++) begin
      if (p != 0) begin
        drain_all();
        write_quantum(phase_quantum[p]);
      end
      // one phase runs with both sides streaming back to back
      idle_pct = (p == 2) ? 0 : 19;
      case (p)
        0: begin
          add_job(16'd0, 1'b1);
          add_job(16'd1, 1'b0);
          add_job(16'd4, 1'b0);
          add_job(16'd5, 1'b0);
          add_job(16'd3, 1'b0);
          add_job(16'd8, 1'b0);
          add_job(16'd0, 1'b0);
          add_job(16'd9, 1'b1);
        end
        1: begin
          add_job(16'd2, 1'b0);
          add_job(16'd0, 1'b0);
          add_job(16'd3, 1'b0);
          add_job(16'd1, 1'b1);
        end
        2: begin
          add_job(16'hFFFF, 1'b0);
          add_job(16'hFFFF, 1'b0);
          add_job(16'd0, 1'b0);
          add_job(16'h8000, 1'b1);
        end
        3: begin
          add_job(16'd0, 1'b0);
          add_job(16'd0, 1'b0);
          add_job(16'd1, 1'b1);
        end
        default: begin
          // overflowing batch: extra jobs are dropped
          add_random_batch(int'($urandom_range(36, MAX_JOBS + 1)));
        end
      endcase
      queued = 0;
      while (queued < RANDOM_PER_PHASE) begin
        jobs = ($urandom_range(5) == 0) ? int'($urandom_range(MAX_JOBS, 20)) :
                                          int'($urandom_range(10, 1));
        add_random_batch(jobs);
        queued += jobs;
      end
    end
    drain_all();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rrsm_pkg.sv
hdl/rrsm_ctrl.sv
hdl/rrsm_datapath.sv
hdl/round_robin_schedule_metrics_unit.sv
sim/testbench.sv
